FILE: rtl/jvmx_pkg.sv
// ----------------------------------------------------------------------------
// jvmx_pkg
// Shared codes, state type and controller/datapath link structs for the
// JVM wide and extended-branch instruction execute block.
// ----------------------------------------------------------------------------
package jvmx_pkg;

   // instruction select codes
   localparam logic [2:0] FUNC_WIDE      = 3'd0;
   localparam logic [2:0] FUNC_IFNULL    = 3'd1;
   localparam logic [2:0] FUNC_IFNONNULL = 3'd2;
   localparam logic [2:0] FUNC_GOTO_W    = 3'd3;
   localparam logic [2:0] FUNC_JSR_W     = 3'd4;

   // opcodes that may follow wide
   localparam logic [7:0] OP_ILOAD  = 8'h15;
   localparam logic [7:0] OP_LLOAD  = 8'h16;
   localparam logic [7:0] OP_DLOAD  = 8'h18;
   localparam logic [7:0] OP_ALOAD  = 8'h19;
   localparam logic [7:0] OP_ISTORE = 8'h36;
   localparam logic [7:0] OP_LSTORE = 8'h37;
   localparam logic [7:0] OP_DSTORE = 8'h39;
   localparam logic [7:0] OP_ASTORE = 8'h3a;
   localparam logic [7:0] OP_IINC   = 8'h84;
   localparam logic [7:0] OP_RET    = 8'ha9;

   // instruction lengths in bytes
   localparam logic [15:0] LEN_WIDE      = 16'd4;
   localparam logic [15:0] LEN_WIDE_IINC = 16'd6;
   localparam logic [15:0] LEN_IF        = 16'd3;
   localparam logic [15:0] LEN_JSR_W     = 16'd5;

   // result status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_RANGE     = 2'd1;
   localparam logic [1:0] STATUS_UNKNOWN   = 2'd2;
   localparam logic [1:0] STATUS_RESERVED  = 2'd3;

   // controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_SECOND,
      ST_HOLD
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic clear_wr;   // write zero at clear counter
      logic capture;    // transaction accepted: latch fields, read local file
      logic exec_wr;    // write-back of store / iinc slot
      logic second_wr;  // second slot of lstore / dstore
      logic out_load;   // load output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last; // clear counter at last entry
      logic two_store;  // current transaction writes two slots
      logic out_free;   // output register can take a result
   } stat_type;

endpackage

FILE: rtl/jvmx_ctrl.sv
// ----------------------------------------------------------------------------
// jvmx_ctrl
// Sequencer: clearing pass after reset, accept, execute / write-back,
// optional second slot write, and hold until the output register is free.
// ----------------------------------------------------------------------------
module jvmx_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  jvmx_pkg::stat_type stat,
   output jvmx_pkg::cmd_type  cmd
);

   jvmx_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= jvmx_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         jvmx_pkg::ST_CLEAR: begin
            if (stat.clear_last) state_in = jvmx_pkg::ST_IDLE;
         end
         jvmx_pkg::ST_IDLE: begin
            if (req_valid) state_in = jvmx_pkg::ST_EXEC;
         end
         jvmx_pkg::ST_EXEC: begin
            if (stat.two_store)     state_in = jvmx_pkg::ST_SECOND;
            else if (stat.out_free) state_in = jvmx_pkg::ST_IDLE;
            else                    state_in = jvmx_pkg::ST_HOLD;
         end
         jvmx_pkg::ST_SECOND: begin
            if (stat.out_free) state_in = jvmx_pkg::ST_IDLE;
            else               state_in = jvmx_pkg::ST_HOLD;
         end
         jvmx_pkg::ST_HOLD: begin
            if (stat.out_free) state_in = jvmx_pkg::ST_IDLE;
         end
         default: state_in = jvmx_pkg::ST_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         jvmx_pkg::ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
         end
         jvmx_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         jvmx_pkg::ST_EXEC: begin
            cmd.exec_wr  = 1'b1;
            cmd.out_load = !stat.two_store && stat.out_free;
         end
         jvmx_pkg::ST_SECOND: begin
            cmd.second_wr = 1'b1;
            cmd.out_load  = stat.out_free;
         end
         jvmx_pkg::ST_HOLD: begin
            cmd.out_load = stat.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

FILE: rtl/jvmx_datapath.sv
// ----------------------------------------------------------------------------
// jvmx_datapath
// Transaction registers, local-variable file (one write, one registered read
// port), instruction decode, pc arithmetic and the output register.
// ----------------------------------------------------------------------------
module jvmx_datapath #(
   parameter int MAX_LOCALS = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  jvmx_pkg::cmd_type   cmd,
   output jvmx_pkg::stat_type  stat,
   input  logic [2:0]          req_func,
   input  logic [7:0]          req_wide_opcode,
   input  logic [15:0]         req_local_index,
   input  logic signed [31:0]  req_immediate,
   input  logic [15:0]         req_instr_addr,
   input  logic [63:0]         req_stack_top,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [15:0]         rsp_next_pc,
   output logic                rsp_push_valid,
   output logic [63:0]         rsp_push_value,
   output logic                rsp_pop_top,
   output logic [1:0]          rsp_status
);

   localparam int          IDX_W     = (MAX_LOCALS > 1) ? $clog2(MAX_LOCALS) : 1;
   localparam logic [16:0] LOCAL_LIM = 17'(MAX_LOCALS);
   localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(MAX_LOCALS - 1);

   // transaction registers
   logic [2:0]  func_ff;
   logic [7:0]  op_ff;
   logic [15:0] idx_ff;
   logic [31:0] imm_ff;
   logic [15:0] addr_ff;
   logic [63:0] top_ff;

   // local file and its read data
   logic [63:0]      local_file_ff [MAX_LOCALS];
   logic [63:0]      rd_data_ff;
   logic [IDX_W-1:0] clr_cnt_ff, clr_cnt_in;

   // output register
   logic        valid_ff;
   logic [15:0] next_pc_ff;
   logic        push_valid_ff;
   logic [63:0] push_value_ff;
   logic        pop_top_ff;
   logic [1:0]  status_ff;

   // decode
   logic        is_load, is_store, is_iinc, is_ret, is_two, known, in_range;
   logic        do_write;
   logic        rd_en;
   logic [16:0] idx_ext;
   logic [15:0] br_pc;
   logic [15:0] nxt_pc;
   logic        nxt_push;
   logic [63:0] nxt_value;
   logic        nxt_pop;
   logic [1:0]  nxt_status;
   logic        is_null, take;
   logic        wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [63:0]      wr_data;

   // capture the transaction
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= req_func;
         op_ff   <= req_wide_opcode;
         idx_ff  <= req_local_index;
         imm_ff  <= unsigned'(req_immediate);
         addr_ff <= req_instr_addr;
         top_ff  <= req_stack_top;
      end
   end

   // clear counter for the post-reset sweep
   assign clr_cnt_in = cmd.clear_wr ? clr_cnt_ff + 1'b1 : clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // instruction decode on captured fields
   always_comb begin
      is_load  = (op_ff >= jvmx_pkg::OP_ILOAD) && (op_ff <= jvmx_pkg::OP_ALOAD);
      is_store = (op_ff >= jvmx_pkg::OP_ISTORE) && (op_ff <= jvmx_pkg::OP_ASTORE);
      is_two   = (op_ff == jvmx_pkg::OP_LLOAD) || (op_ff == jvmx_pkg::OP_DLOAD) ||
                 (op_ff == jvmx_pkg::OP_LSTORE) || (op_ff == jvmx_pkg::OP_DSTORE);
   end

   assign is_iinc  = (op_ff == jvmx_pkg::OP_IINC);
   assign is_ret   = (op_ff == jvmx_pkg::OP_RET);
   assign known    = is_load || is_store || is_iinc || is_ret;
   assign idx_ext  = {1'b0, idx_ff};
   assign in_range = (idx_ext < LOCAL_LIM) && (!is_two || (idx_ext + 17'd1 < LOCAL_LIM));
   assign do_write = (func_ff == jvmx_pkg::FUNC_WIDE) && known && in_range &&
                     (is_store || is_iinc);

   // result of the captured instruction
   assign br_pc   = addr_ff + imm_ff[15:0];
   assign is_null = (top_ff == 64'd0);
   assign take    = (func_ff == jvmx_pkg::FUNC_IFNULL) ? is_null : !is_null;

   always_comb begin
      nxt_pc     = addr_ff;
      nxt_push   = 1'b0;
      nxt_value  = 64'd0;
      nxt_pop    = 1'b0;
      nxt_status = jvmx_pkg::STATUS_OK;
      case (func_ff)
         jvmx_pkg::FUNC_WIDE: begin
            nxt_pc = addr_ff + (is_iinc ? jvmx_pkg::LEN_WIDE_IINC : jvmx_pkg::LEN_WIDE);
            if (!known) begin
               nxt_status = jvmx_pkg::STATUS_UNKNOWN;
            end else if (!in_range) begin
               nxt_status = jvmx_pkg::STATUS_RANGE;
            end else if (is_load) begin
               nxt_push  = 1'b1;
               nxt_value = rd_data_ff;
            end else if (is_store) begin
               nxt_pop = 1'b1;
            end else if (is_ret) begin
               nxt_pc = rd_data_ff[15:0];
            end
         end
         jvmx_pkg::FUNC_IFNULL, jvmx_pkg::FUNC_IFNONNULL: begin
            nxt_pop = 1'b1;
            nxt_pc  = take ? br_pc : addr_ff + jvmx_pkg::LEN_IF;
         end
         jvmx_pkg::FUNC_GOTO_W: begin
            nxt_pc = br_pc;
         end
         jvmx_pkg::FUNC_JSR_W: begin
            nxt_push  = 1'b1;
            nxt_value = {48'd0, addr_ff + jvmx_pkg::LEN_JSR_W};
            nxt_pc    = br_pc;
         end
         default: begin
            nxt_status = jvmx_pkg::STATUS_UNKNOWN;
         end
      endcase
   end

   // write port select: clear sweep, execute write-back, second slot
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_cnt_ff;
      wr_data = 64'd0;
      if (cmd.clear_wr) begin
         wr_en = 1'b1;
      end else if (cmd.exec_wr) begin
         wr_en   = do_write;
         wr_addr = idx_ff[IDX_W-1:0];
         wr_data = is_iinc ? {rd_data_ff[63:32], rd_data_ff[31:0] + imm_ff} : top_ff;
      end else if (cmd.second_wr) begin
         wr_en   = 1'b1;
         wr_addr = idx_ff[IDX_W-1:0] + 1'b1;
         wr_data = top_ff;
      end
   end

   assign rd_en = cmd.capture && ({1'b0, req_local_index} < LOCAL_LIM);

   // local file write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         local_file_ff[wr_addr] <= wr_data;
      end
   end

   // local file read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= local_file_ff[req_local_index[IDX_W-1:0]];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         next_pc_ff    <= nxt_pc;
         push_valid_ff <= nxt_push;
         push_value_ff <= nxt_value;
         pop_top_ff    <= nxt_pop;
         status_ff     <= nxt_status;
      end
   end

   assign stat.clear_last = (clr_cnt_ff == CLR_LAST);
   assign stat.two_store  = do_write && is_two;
   assign stat.out_free   = !valid_ff || rsp_ready;

   assign rsp_valid      = valid_ff;
   assign rsp_next_pc    = next_pc_ff;
   assign rsp_push_valid = push_valid_ff;
   assign rsp_push_value = push_value_ff;
   assign rsp_pop_top    = pop_top_ff;
   assign rsp_status     = status_ff;

endmodule

FILE: rtl/jvm_extended_instruction_execute.sv
// Sequence: an accepted transaction reads the local file; EXEC writes back
// and loads the result, SECOND writes the second slot of wide lstore/dstore,
// and HOLD waits while the output register is stalled. No new transaction
// is taken until the result is loaded (single local-file write port).
// Reset: synchronous; a clearing pass over every entry zeroes the local
// file, with req_ready low until it completes.
// ----------------------------------------------------------------------------
// jvm_extended_instruction_execute
// Executes JVM wide load/store/iinc/ret, ifnull, ifnonnull, goto_w and jsr_w
// against an internal local-variable file.
// ----------------------------------------------------------------------------
module jvm_extended_instruction_execute #(
   parameter int MAX_LOCALS = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_func,
   input  logic [7:0]         req_wide_opcode,
   input  logic [15:0]        req_local_index,
   input  logic signed [31:0] req_immediate,
   input  logic [15:0]        req_instr_addr,
   input  logic [63:0]        req_stack_top,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [15:0]        rsp_next_pc,
   output logic               rsp_push_valid,
   output logic [63:0]        rsp_push_value,
   output logic               rsp_pop_top,
   output logic [1:0]         rsp_status
);

   jvmx_pkg::cmd_type  cmd;
   jvmx_pkg::stat_type stat;

   // sequencer
   jvmx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath and local file
   jvmx_datapath #(
      .MAX_LOCALS (MAX_LOCALS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_func        (req_func),
      .req_wide_opcode (req_wide_opcode),
      .req_local_index (req_local_index),
      .req_immediate   (req_immediate),
      .req_instr_addr  (req_instr_addr),
      .req_stack_top   (req_stack_top),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_next_pc     (rsp_next_pc),
      .rsp_push_valid  (rsp_push_valid),
      .rsp_push_value  (rsp_push_value),
      .rsp_pop_top     (rsp_pop_top),
      .rsp_status      (rsp_status)
   );

`ifndef NO_ASSERTIONS
   // clearing pass follows reset: no transaction taken right after it
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("req_ready high right after reset");

   // every transaction passes through the execute state before the next is accepted
   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("transaction accepted in consecutive cycles");

   // a failed instruction neither pushes nor pops
   a_error_no_effect: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != jvmx_pkg::STATUS_OK) |-> !rsp_push_valid && !rsp_pop_top)
      else $error("error result with stack effect");

   // reserved status code never produced
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != jvmx_pkg::STATUS_RESERVED)
      else $error("reserved status code");
`endif

endmodule
